// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, quiet while reset is held low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge
`define AST_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/pidlev_pkg.sv -----
// ----------------------------------------------------------------------------
// pidlev_pkg
// Widths, register codes, request structs and saturation helpers shared by
// the levitation PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidlev_pkg;

    // Field and datapath widths
    localparam int W_SIG      = 32;
    localparam int W_GAIN     = 31;
    localparam int W_MM       = 13;
    localparam int W_REF      = 23;
    localparam int W_DRV      = 23;
    localparam int W_CAL      = 24;
    localparam int W_POLE     = 25;
    localparam int W_LIM      = 23;
    localparam int W_ACC      = 2 * W_SIG;
    localparam int W_MAG      = 40;
    localparam int W_DIVD     = 36;
    localparam int W_DVSR     = 5;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 32;
    localparam int W_WIDE     = W_SIG + 2;

    // Serial step counts
    localparam int MUL_STEPS = W_SIG;
    localparam int DIV_STEPS = W_DIVD;

    // Constant divisors and rounding terms
    localparam logic [W_DVSR-1:0] DIV_TEN      = 5'd10;
    localparam logic [W_DVSR-1:0] DIV_EIGHTEEN = 5'd18;
    localparam logic [W_DIVD-1:0] MM_ROUND     = 36'd5;
    localparam logic [W_DIVD-1:0] AW_ROUND     = 36'd9;
    // Half an LSB of Q8.24, pre-placed in the upper accumulator half
    localparam logic [W_SIG-1:0]  ROUND_HALF   = 32'h0080_0000;

    // Register reset values
    localparam logic [W_CAL-1:0]  RST_CAL  = 24'd6553600;
    localparam logic [W_GAIN-1:0] RST_KP   = 31'd111352;
    localparam logic [W_GAIN-1:0] RST_KI   = 31'd253;
    localparam logic [W_POLE-1:0] RST_AD   = 25'd631459;
    localparam logic [W_GAIN-1:0] RST_BD   = 31'd3157295;
    localparam logic [W_POLE-1:0] RST_BETA = 25'd11744051;
    localparam logic [W_LIM-1:0]  RST_UMIN = 23'd327680;
    localparam logic [W_LIM-1:0]  RST_UMAX = 23'd589824;

    // Saturation bounds
    localparam logic signed [W_WIDE-1:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [W_WIDE-1:0] SAT_LO = -34'sd2147483648;
    localparam logic [W_MAG-1:0]         MAG_POS_MAX = 40'h00_7FFF_FFFF;
    localparam logic [W_MAG-1:0]         MAG_NEG_MAX = 40'h00_8000_0000;
    localparam logic [W_SIG-1:0]         SIG_MAX = 32'h7FFF_FFFF;
    localparam logic [W_SIG-1:0]         SIG_MIN = 32'h8000_0000;

    typedef logic signed [W_SIG-1:0] t_sig;

    // Configuration register codes
    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_CAL  = 3'd0,
        CFG_KP   = 3'd1,
        CFG_KI   = 3'd2,
        CFG_AD   = 3'd3,
        CFG_BD   = 3'd4,
        CFG_BETA = 3'd5,
        CFG_UMIN = 3'd6,
        CFG_UMAX = 3'd7
    } t_cfg_idx;

    // Request to the serial multiplier
    typedef struct packed {
        logic              start;
        t_sig              value;
        logic [W_GAIN-1:0] gain;
    } t_mul_req;

    // Request to the serial constant divider
    typedef struct packed {
        logic              start;
        logic [W_DIVD-1:0] dividend;
        logic [W_DVSR-1:0] divisor;
    } t_div_req;

    // Sign-extend a signal by two bits for saturating sums
    function automatic logic signed [W_WIDE-1:0] f_sx(input t_sig v);
        return {{2{v[W_SIG-1]}}, v};
    endfunction

    // Clamp a widened sum to the signed 32-bit range
    function automatic t_sig f_sat34(input logic signed [W_WIDE-1:0] v);
        t_sig r;
        if (v > SAT_HI) begin
            r = SIG_MAX;
        end else if (v < SAT_LO) begin
            r = SIG_MIN;
        end else begin
            r = v[W_SIG-1:0];
        end
        return r;
    endfunction

    // Apply a sign to a magnitude and clamp to the signed 32-bit range
    function automatic t_sig f_sat_mag(input logic neg, input logic [W_MAG-1:0] mag);
        t_sig r;
        if (!neg) begin
            if (mag > MAG_POS_MAX) r = SIG_MAX;
            else                   r = mag[W_SIG-1:0];
        end else begin
            if (mag > MAG_NEG_MAX) r = SIG_MIN;
            else                   r = {W_SIG{1'b0}} - mag[W_SIG-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/pidlev_if.sv -----
// ----------------------------------------------------------------------------
// pidlev channel interfaces
// Valid/ready channels for samples, drive results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample channel: range reading and reference
interface pidlev_in_if;
    import pidlev_pkg::*;
    logic              valid;
    logic              ready;
    logic [W_MM-1:0]   range_mm;
    logic [W_REF-1:0]  target_position;
    modport source (output valid, range_mm, target_position, input ready);
    modport sink   (input valid, range_mm, target_position, output ready);
endinterface

// Result channel: clamped drive and limit flag
interface pidlev_out_if;
    import pidlev_pkg::*;
    logic              valid;
    logic              ready;
    logic [W_DRV-1:0]  drive;
    logic              at_limit;
    modport source (output valid, drive, at_limit, input ready);
    modport sink   (input valid, drive, at_limit, output ready);
endinterface

// Register write channel
interface pidlev_cfg_if;
    import pidlev_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [W_CFG_IDX-1:0]  reg_index;
    logic [W_CFG_DATA-1:0] data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ----- src/pidlev_ser_mul.sv -----
// ----------------------------------------------------------------------------
// pidlev_ser_mul
// Bit-serial signal-by-gain multiplier: Q16.16 times Q8.24, one gain bit per
// cycle, rounded half away from zero and saturated to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module pidlev_ser_mul (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire pidlev_pkg::t_mul_req i_req,
    output logic                o_done,
    output pidlev_pkg::t_sig    o_result
);
    import pidlev_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(MUL_STEPS - 1);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [W_SIG-1:0]  r_mag;
    logic [W_SIG-1:0]  r_gain;
    logic [W_ACC-1:0]  r_acc;
    logic              r_neg;
    logic [W_SIG:0]    w_sum;

    // Add the magnitude into the upper half when the current gain bit is set
    assign w_sum = {1'b0, r_acc[W_ACC-1:W_SIG]}
                 + (r_gain[0] ? {1'b0, r_mag} : {(W_SIG+1){1'b0}});

    // Control: count the gain bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift and add
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg  <= i_req.value[W_SIG-1];
            r_mag  <= i_req.value[W_SIG-1] ? ({W_SIG{1'b0}} - i_req.value) : i_req.value;
            r_gain <= {1'b0, i_req.gain};
            r_acc  <= {ROUND_HALF, {W_SIG{1'b0}}};
        end else if (r_busy) begin
            r_gain <= {1'b0, r_gain[W_SIG-1:1]};
            r_acc  <= {w_sum, r_acc[W_SIG-1:1]};
        end
    end

    // Drop the 24 fraction bits of the gain, then apply sign and clamp
    assign o_result = f_sat_mag(r_neg, r_acc[W_ACC-1:W_ACC-W_MAG]);
    assign o_done   = r_done;

endmodule

`default_nettype wire

// ----- src/pidlev_ser_div.sv -----
// ----------------------------------------------------------------------------
// pidlev_ser_div
// Restoring divider by a small constant divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pidlev_ser_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire pidlev_pkg::t_div_req  i_req,
    output logic                       o_done,
    output logic [pidlev_pkg::W_DIVD-1:0] o_quot
);
    import pidlev_pkg::*;

    localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [W_DIVD-1:0] r_num;
    logic [W_DVSR-1:0] r_rem;
    logic [W_DVSR-1:0] r_dvsr;
    logic [W_DVSR:0]   w_trial;
    logic              w_ge;
    logic [W_DVSR:0]   w_diff;

    // Bring down the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_num[W_DIVD-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvsr});
    assign w_diff  = w_trial - {1'b0, r_dvsr};

    // Control: count the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out at the top, quotient in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.dividend;
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W_DVSR-1:0] : w_trial[W_DVSR-1:0];
            r_num <= {r_num[W_DIVD-2:0], w_ge};
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- src/pid_levitation_controller_top.sv -----
// One sample is processed at a time: the input is ready only while idle, and the
// next sample is taken after the drive beat is loaded. Each sample uses four or five
// bit-serial products and one or two serial divisions; with a zero integral gain the
// integral update is skipped.
// Reset (synchronous, active low) restores the default registers and clears
// the stored position, integral and derivative terms.
// ----------------------------------------------------------------------------
// pid_levitation_controller_top
// Levitation PID with setpoint weighting, filtered derivative on position and
// back-calculation anti-windup, sequenced over a shared serial multiplier
// and a serial constant divider.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pid_levitation_controller_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pidlev_in_if.sink    i_in,
    pidlev_out_if.source o_out,
    pidlev_cfg_if.sink   i_cfg
);
    import pidlev_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_DIV_MM  = 19'h00002,
        S_POS     = 19'h00004,
        S_W_WAIT  = 19'h00008,
        S_P_GO    = 19'h00010,
        S_P_WAIT  = 19'h00020,
        S_DP_GO   = 19'h00040,
        S_DP_WAIT = 19'h00080,
        S_DK_GO   = 19'h00100,
        S_DK_WAIT = 19'h00200,
        S_D       = 19'h00400,
        S_U       = 19'h00800,
        S_CLAMP   = 19'h01000,
        S_I_GO    = 19'h02000,
        S_I_WAIT  = 19'h04000,
        S_AW_GO   = 19'h08000,
        S_AW_WAIT = 19'h10000,
        S_INT     = 19'h20000,
        S_DONE    = 19'h40000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [W_CAL-1:0]  r_cal;
    logic [W_GAIN-1:0] r_kp;
    logic [W_GAIN-1:0] r_ki;
    logic [W_POLE-1:0] r_ad;
    logic [W_GAIN-1:0] r_bd;
    logic [W_POLE-1:0] r_beta;
    logic [W_LIM-1:0]  r_umin;
    logic [W_LIM-1:0]  r_umax;

    // Controller state
    t_sig r_last;
    t_sig r_integ;
    t_sig r_deriv;

    // Per-sample working registers
    logic [W_REF-1:0] r_ref;
    t_sig r_y, r_wref, r_dy, r_e, r_p, r_dpole, r_dkick, r_dnew;
    t_sig r_u, r_usat, r_diff, r_ie, r_aw;
    logic r_lim;

    // Output register
    logic             r_out_valid;
    logic [W_DRV-1:0] r_drive;
    logic             r_at_limit;

    // Serial units
    t_mul_req          w_mul_req;
    logic              w_mul_done;
    t_sig              w_mul_res;
    t_div_req          w_div_req;
    logic              w_div_done;
    logic [W_DIVD-1:0] w_div_quot;

    logic              w_in_acc;
    logic              w_out_load;
    t_sig              n_perr;
    t_sig              w_umin;
    t_sig              w_umax;
    logic [W_SIG-1:0]  w_aw_mag;
    logic [W_DIVD-1:0] w_aw_divd;
    logic [W_DIVD-1:0] w_mm_divd;

    // Sequencer groupings for the checks
    logic              w_mul_wait;
    logic              w_div_wait;
    logic              w_int_step;
    logic              w_done_step;

    // Handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid    = r_out_valid;
    assign o_out.drive    = r_drive;
    assign o_out.at_limit = r_at_limit;

    // Operand helpers
    assign w_umin    = t_sig'({{(W_SIG-W_LIM){1'b0}}, r_umin});
    assign w_umax    = t_sig'({{(W_SIG-W_LIM){1'b0}}, r_umax});
    assign n_perr    = f_sat34(f_sx(r_wref) - f_sx(r_y));
    assign w_mm_divd = {{(W_DIVD-W_MM-16){1'b0}}, i_in.range_mm, 16'd0} + MM_ROUND;
    assign w_aw_mag  = r_diff[W_SIG-1] ? ({W_SIG{1'b0}} - r_diff) : r_diff;
    assign w_aw_divd = ({{(W_DIVD-W_SIG){1'b0}}, w_aw_mag} << 4)
                     + ({{(W_DIVD-W_SIG){1'b0}}, w_aw_mag} << 2) + AW_ROUND;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal  <= RST_CAL;
            r_kp   <= RST_KP;
            r_ki   <= RST_KI;
            r_ad   <= RST_AD;
            r_bd   <= RST_BD;
            r_beta <= RST_BETA;
            r_umin <= RST_UMIN;
            r_umax <= RST_UMAX;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.reg_index))
                CFG_CAL:  r_cal  <= i_cfg.data[W_CAL-1:0];
                CFG_KP:   r_kp   <= i_cfg.data[W_GAIN-1:0];
                CFG_KI:   r_ki   <= i_cfg.data[W_GAIN-1:0];
                CFG_AD:   r_ad   <= i_cfg.data[W_POLE-1:0];
                CFG_BD:   r_bd   <= i_cfg.data[W_GAIN-1:0];
                CFG_BETA: r_beta <= i_cfg.data[W_POLE-1:0];
                CFG_UMIN: r_umin <= i_cfg.data[W_LIM-1:0];
                CFG_UMAX: r_umax <= i_cfg.data[W_LIM-1:0];
                default:  ;
            endcase
        end
    end

    // Issue multiplier requests
    always_comb begin
        w_mul_req = '0;
        case (r_state)
            S_POS: begin
                w_mul_req.start = 1'b1;
                w_mul_req.value = t_sig'({{(W_SIG-W_REF){1'b0}}, r_ref});
                w_mul_req.gain  = {{(W_GAIN-W_POLE){1'b0}}, r_beta};
            end
            S_P_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.value = n_perr;
                w_mul_req.gain  = r_kp;
            end
            S_DP_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.value = r_deriv;
                w_mul_req.gain  = {{(W_GAIN-W_POLE){1'b0}}, r_ad};
            end
            S_DK_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.value = r_dy;
                w_mul_req.gain  = r_bd;
            end
            S_I_GO: begin
                w_mul_req.start = 1'b1;
                w_mul_req.value = r_e;
                w_mul_req.gain  = r_ki;
            end
            default: ;
        endcase
    end

    // Issue divider requests: range to centimetres, then the anti-windup scale
    always_comb begin
        w_div_req = '0;
        case (r_state)
            S_IDLE: begin
                w_div_req.start    = w_in_acc;
                w_div_req.dividend = w_mm_divd;
                w_div_req.divisor  = DIV_TEN;
            end
            S_AW_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_aw_divd;
                w_div_req.divisor  = DIV_EIGHTEEN;
            end
            default: ;
        endcase
    end

    pidlev_ser_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mul_req),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    pidlev_ser_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_in_acc)   n_state = S_DIV_MM;
            S_DIV_MM:  if (w_div_done) n_state = S_POS;
            S_POS:     n_state = S_W_WAIT;
            S_W_WAIT:  if (w_mul_done) n_state = S_P_GO;
            S_P_GO:    n_state = S_P_WAIT;
            S_P_WAIT:  if (w_mul_done) n_state = S_DP_GO;
            S_DP_GO:   n_state = S_DP_WAIT;
            S_DP_WAIT: if (w_mul_done) n_state = S_DK_GO;
            S_DK_GO:   n_state = S_DK_WAIT;
            S_DK_WAIT: if (w_mul_done) n_state = S_D;
            S_D:       n_state = S_U;
            S_U:       n_state = S_CLAMP;
            S_CLAMP:   n_state = (r_ki != '0) ? S_I_GO : S_DONE;
            S_I_GO:    n_state = S_I_WAIT;
            S_I_WAIT:  if (w_mul_done) n_state = S_AW_GO;
            S_AW_GO:   n_state = S_AW_WAIT;
            S_AW_WAIT: if (w_div_done) n_state = S_INT;
            S_INT:     n_state = S_DONE;
            S_DONE:    if (w_out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers for one sample
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) r_ref <= i_in.target_position;
            end
            S_DIV_MM: begin
                // Position is calibration minus the range in centimetres
                if (w_div_done) begin
                    r_y <= f_sat34(f_sx(t_sig'({{(W_SIG-W_CAL){1'b0}}, r_cal}))
                                   - f_sx(t_sig'(w_div_quot[W_SIG-1:0])));
                end
            end
            S_W_WAIT: begin
                if (w_mul_done) r_wref <= w_mul_res;
            end
            S_P_GO: begin
                r_dy <= f_sat34(f_sx(r_y) - f_sx(r_last));
                r_e  <= f_sat34(f_sx(t_sig'({{(W_SIG-W_REF){1'b0}}, r_ref})) - f_sx(r_y));
            end
            S_P_WAIT: begin
                if (w_mul_done) r_p <= w_mul_res;
            end
            S_DP_WAIT: begin
                if (w_mul_done) r_dpole <= w_mul_res;
            end
            S_DK_WAIT: begin
                if (w_mul_done) r_dkick <= w_mul_res;
            end
            S_D: begin
                r_dnew <= f_sat34(f_sx(r_dpole) - f_sx(r_dkick));
            end
            S_U: begin
                r_u <= f_sat34(f_sx(r_p) + f_sx(r_integ) + f_sx(r_dnew));
            end
            S_CLAMP: begin
                // When the limits are crossed, the lower limit wins below it, the upper above it
                if (r_u < w_umin)      r_usat <= w_umin;
                else if (r_u > w_umax) r_usat <= w_umax;
                else                   r_usat <= r_u;
                r_lim <= (r_u < w_umin) || (r_u > w_umax);
            end
            S_I_GO: begin
                r_diff <= f_sat34(f_sx(r_usat) - f_sx(r_u));
            end
            S_I_WAIT: begin
                if (w_mul_done) r_ie <= w_mul_res;
            end
            S_AW_WAIT: begin
                if (w_div_done) begin
                    r_aw <= f_sat_mag(r_diff[W_SIG-1],
                                      {{(W_MAG-W_DIVD){1'b0}}, w_div_quot});
                end
            end
            default: ;
        endcase
    end

    // Controller state: integral, derivative and previous position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_deriv <= '0;
            r_last  <= '0;
        end else begin
            if (r_state == S_INT) begin
                r_integ <= f_sat34(f_sx(r_integ) + f_sx(r_ie) + f_sx(r_aw));
            end
            if (w_out_load) begin
                r_deriv <= r_dnew;
                r_last  <= r_y;
            end
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_drive    <= r_usat[W_DRV-1:0];
            r_at_limit <= r_lim;
        end
    end

    // Group the sequencer states that the checks refer to
    assign w_mul_wait  = (r_state == S_W_WAIT) || (r_state == S_P_WAIT)
                      || (r_state == S_DP_WAIT) || (r_state == S_DK_WAIT)
                      || (r_state == S_I_WAIT);
    assign w_div_wait  = (r_state == S_DIV_MM) || (r_state == S_AW_WAIT);
    assign w_int_step  = (r_state == S_INT);
    assign w_done_step = (r_state == S_DONE);

    // Checks
    `AST_IMPLY(a_mul_done_waited, w_mul_done, w_mul_wait, "multiplier done outside a wait")
    `AST_IMPLY(a_div_done_waited, w_div_done, w_div_wait, "divider done outside a wait")
    `AST_IMPLY(a_integ_only_update, !$stable(r_integ), $past(w_int_step), "integral moved early")
    `AST_IMPLY(a_result_from_done, $rose(r_out_valid), $past(w_done_step), "stray result beat")

endmodule

`default_nettype wire

// ----- tb/sv/pid_levitation_controller_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_levitation_controller_top_tb
// Self-checking bench for the levitation PID. Samples are driven over the
// input channel under random gaps. Each accepted sample is run through a
// fixed-point model of the controller kept in a scoreboard. Drive beats are
// checked in order against it. Register settings change between phases:
// reset values, typical gains, all zeros, all ones, crossed limits, frozen
// integral and fully random words.
// ----------------------------------------------------------------------------
module pid_levitation_controller_top_tb;
    import pidlev_pkg::*;

    localparam int CLK_HIGH        = 2;
    localparam int CLK_LOW         = 2;
    localparam int RESET_CYCLES    = 5;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int HOLD_CYCLES     = 1500;
    localparam int DRAIN_CYCLES    = 300;
    localparam int STALL_LIMIT     = 6000;
    localparam int MAX_REPORTS     = 40;
    localparam int PRESSURE_PHASE  = 3;
    localparam int PAUSE_PHASE     = 8;

    typedef enum {
        SET_DEFAULT,
        SET_TYPICAL,
        SET_ZERO,
        SET_ONES,
        SET_CROSSED,
        SET_FROZEN,
        SET_RANDOM
    } t_setting;

    typedef struct {
        logic [W_DRV-1:0] drive;
        logic             at_limit;
    } t_drive_beat;

    // ------------------------------------------------------------------------
    // Controller model and ordered store of expected drive beats
    // ------------------------------------------------------------------------
    class levitation_drive_scoreboard;
        bit [W_CAL-1:0]  calib;
        bit [W_GAIN-1:0] kp;
        bit [W_GAIN-1:0] ki;
        bit [W_POLE-1:0] ad;
        bit [W_GAIN-1:0] bd;
        bit [W_POLE-1:0] beta;
        bit [W_LIM-1:0]  lim_lo;
        bit [W_LIM-1:0]  lim_hi;
        int              prev_pos;
        int              integ;
        int              deriv;
        t_drive_beat     pending_drive[$];
        int              errors;
        int              n_checked;
        int              n_limited;

        function new();
            calib     = 24'd6553600;
            kp        = 31'd111352;
            ki        = 31'd253;
            ad        = 25'd631459;
            bd        = 31'd3157295;
            beta      = 25'd11744051;
            lim_lo    = 23'd327680;
            lim_hi    = 23'd589824;
            prev_pos  = 0;
            integ     = 0;
            deriv     = 0;
            errors    = 0;
            n_checked = 0;
            n_limited = 0;
        endfunction

        function int sat_word(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return int'(v);
        endfunction

        // Signal times Q8.24 gain, rounded half away from zero
        function int scale_by_gain(int s, longint g);
            longint mag;
            longint r;
            mag = (s < 0) ? -longint'(s) : longint'(s);
            r = (mag * g + 64'sd8388608) >>> 24;
            return sat_word((s < 0) ? -r : r);
        endfunction

        // Signal times 10/9, rounded half away from zero
        function int scale_ten_ninths(int s);
            longint mag;
            longint r;
            mag = (s < 0) ? -longint'(s) : longint'(s);
            r = (mag * 20 + 9) / 18;
            return sat_word((s < 0) ? -r : r);
        endfunction

        function void write_reg(t_cfg_idx idx, bit [W_CFG_DATA-1:0] data);
            case (idx)
                CFG_CAL:  calib  = data[W_CAL-1:0];
                CFG_KP:   kp     = data[W_GAIN-1:0];
                CFG_KI:   ki     = data[W_GAIN-1:0];
                CFG_AD:   ad     = data[W_POLE-1:0];
                CFG_BD:   bd     = data[W_GAIN-1:0];
                CFG_BETA: beta   = data[W_POLE-1:0];
                CFG_UMIN: lim_lo = data[W_LIM-1:0];
                CFG_UMAX: lim_hi = data[W_LIM-1:0];
                default: ;
            endcase
        endfunction

        // Advance the controller by one sample and queue its drive beat
        function void note_sample(bit [W_MM-1:0] mm, bit [W_REF-1:0] tgt);
            longint      mm_q;
            longint      wref;
            longint      lo;
            longint      hi;
            longint      usat;
            int          y;
            int          perr;
            int          p;
            int          dy;
            int          dpole;
            int          dkick;
            int          d;
            int          u;
            int          e;
            int          ie;
            int          aw;
            bit          lim;
            t_drive_beat beat;

            mm_q  = (longint'(mm) * 65536 + 5) / 10;
            y     = sat_word(longint'(calib) - mm_q);
            wref  = (longint'(beta) * longint'(tgt) + 64'sd8388608) >>> 24;
            perr  = sat_word(wref - longint'(y));
            p     = scale_by_gain(perr, longint'(kp));
            dy    = sat_word(longint'(y) - longint'(prev_pos));
            dpole = scale_by_gain(deriv, longint'(ad));
            dkick = scale_by_gain(dy, longint'(bd));
            d     = sat_word(longint'(dpole) - longint'(dkick));
            u     = sat_word(longint'(p) + longint'(integ) + longint'(d));
            e     = sat_word(longint'(tgt) - longint'(y));

            // When the limits are crossed, the low limit wins below it, the high above it
            lo = longint'(lim_lo);
            hi = longint'(lim_hi);
            if (longint'(u) < lo) usat = lo;
            else if (longint'(u) > hi) usat = hi;
            else usat = longint'(u);
            lim = (longint'(u) < lo) || (longint'(u) > hi);

            // Integral with back-calculation; frozen at zero gain
            if (ki != 0) begin
                ie    = scale_by_gain(e, longint'(ki));
                aw    = scale_ten_ninths(sat_word(usat - longint'(u)));
                integ = sat_word(longint'(integ) + longint'(ie) + longint'(aw));
            end
            deriv    = d;
            prev_pos = y;

            beat.drive    = usat[W_DRV-1:0];
            beat.at_limit = lim;
            if (lim) n_limited++;
            pending_drive.push_back(beat);
        endfunction

        function void check_drive(logic [W_DRV-1:0] drive, logic at_limit);
            t_drive_beat want;
            if (pending_drive.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: drive beat with none expected: drive=%h at_limit=%b",
                             $time, drive, at_limit);
                return;
            end
            want = pending_drive.pop_front();
            n_checked++;
            if (drive !== want.drive) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: drive mismatch: expected %h, got %h",
                             $time, want.drive, drive);
            end
            if (at_limit !== want.at_limit) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: at_limit mismatch: expected %b, got %b",
                             $time, want.at_limit, at_limit);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pidlev_in_if  in_bus();
    pidlev_out_if out_bus();
    pidlev_cfg_if cfg_bus();

    pid_levitation_controller_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    levitation_drive_scoreboard sb;

    bit smooth;
    bit hold_request;
    int n_sent;
    int walk_mm;
    int walk_tgt;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Result receiver: random stalls, plus one long hold when requested
    initial begin
        int r;
        int stall_left;
        stall_left  = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else if (smooth) begin
                out_bus.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    out_bus.ready <= 1'b1;
                end else begin
                    out_bus.ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 300);
                end
            end
        end
    end

    // Check every accepted drive beat
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
            sb.check_drive(out_bus.drive, out_bus.at_limit);
    end

    // Watchdog: end the run when no beat moves on any channel for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
                (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("pid_levitation_controller_top_tb: FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (smooth || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Offer one sample, hold it until accepted, then idle for a random gap
    task automatic send_sample(bit [W_MM-1:0] mm, bit [W_REF-1:0] tgt);
        int gap;
        @(negedge i_clk);
        in_bus.valid           <= 1'b1;
        in_bus.range_mm        <= mm;
        in_bus.target_position <= tgt;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        sb.note_sample(mm, tgt);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Mostly a slowly moving ball with a held reference; some raw noise
    task automatic send_random_sample();
        int          r;
        logic [31:0] raw_mm;
        logic [31:0] raw_tgt;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            raw_mm  = $urandom;
            raw_tgt = $urandom;
            send_sample(raw_mm[W_MM-1:0], raw_tgt[W_REF-1:0]);
        end else begin
            if (r < 25) walk_mm = $urandom_range(0, 1000);
            else walk_mm = walk_mm + $urandom_range(0, 30) - 15;
            if (walk_mm < 0) walk_mm = 0;
            if (walk_mm > 1100) walk_mm = 1100;
            if ($urandom_range(0, 9) == 0) walk_tgt = $urandom_range(0, 6553600);
            send_sample(walk_mm[W_MM-1:0], walk_tgt[W_REF-1:0]);
        end
    endtask

    // Drop valid and wait for every outstanding drive beat
    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (sb.pending_drive.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [W_CFG_DATA-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.data      <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Load one full register setting
    task automatic program_setting(t_setting s);
        bit [31:0] cal;
        bit [31:0] kp;
        bit [31:0] ki;
        bit [31:0] ad;
        bit [31:0] bd;
        bit [31:0] beta;
        bit [31:0] lo;
        bit [31:0] hi;
        cal  = $urandom_range(0, 13107200);
        kp   = $urandom_range(0, 2000000);
        ki   = $urandom_range(1, 200000);
        ad   = $urandom_range(0, 16777216);
        bd   = $urandom_range(0, 20000000);
        beta = $urandom_range(0, 16777216);
        lo   = $urandom_range(0, 6553600);
        hi   = $urandom_range(lo, 6553600);
        case (s)
            SET_ZERO: begin
                cal = '0; kp = '0; ki = '0; ad = '0;
                bd  = '0; beta = '0; lo = '0; hi = '0;
            end
            SET_ONES: begin
                cal = '1; kp = '1; ki = '1; ad = '1;
                bd  = '1; beta = '1; lo = '1; hi = '1;
            end
            SET_CROSSED: begin
                lo = $urandom_range(1, 6553600);
                hi = $urandom_range(0, lo - 1);
            end
            SET_FROZEN: ki = '0;
            SET_RANDOM: begin
                cal = $urandom; kp = $urandom; ki = $urandom; ad = $urandom;
                bd  = $urandom; beta = $urandom; lo = $urandom; hi = $urandom;
            end
            default: ;
        endcase
        write_reg(CFG_CAL, cal);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_AD, ad);
        write_reg(CFG_BD, bd);
        write_reg(CFG_BETA, beta);
        write_reg(CFG_UMIN, lo);
        write_reg(CFG_UMAX, hi);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_setting plan [N_PHASES];
        int       n_random;

        plan = '{SET_DEFAULT, SET_TYPICAL, SET_ZERO, SET_TYPICAL, SET_ONES, SET_CROSSED,
                 SET_FROZEN, SET_RANDOM, SET_TYPICAL, SET_CROSSED, SET_RANDOM, SET_TYPICAL};
        sb           = new();
        smooth       = 1'b0;
        hold_request = 1'b0;
        n_sent       = 0;
        walk_mm      = 500;
        walk_tgt     = 3276800;

        i_rst_n                = 1'b0;
        in_bus.valid           = 1'b0;
        in_bus.range_mm        = '0;
        in_bus.target_position = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.reg_index      = CFG_CAL;
        cfg_bus.data           = '0;

        // Hold reset, release on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: field extremes, alternating bits, then a settle and
        // steps that push the drive past both limits
        send_sample(13'd0, 23'd0);
        send_sample(13'h1FFF, 23'd0);
        send_sample(13'd0, 23'h7FFFFF);
        send_sample(13'h1FFF, 23'h7FFFFF);
        send_sample(13'h1555, 23'h2AAAAA);
        send_sample(13'h0AAA, 23'h555555);
        send_sample(13'd1000, 23'd6553600);
        send_sample(13'd1000, 23'd0);
        repeat (4) send_sample(13'd500, 23'd3276800);
        send_sample(13'd100, 23'd3276800);
        send_sample(13'd900, 23'd3276800);
        send_sample(13'd950, 23'd6553600);
        send_sample(13'd0, 23'd0);
        n_random = ITEMS_PER_PHASE - n_sent;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (plan[ph] != SET_DEFAULT) begin
                wait_drained();
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
                program_setting(plan[ph]);
                n_random = ITEMS_PER_PHASE;
            end
            smooth = (ph % 4 == 1);
            if (ph == PRESSURE_PHASE) hold_request = 1'b1;
            for (int k = 0; k < n_random; k++) begin
                if (ph == PAUSE_PHASE && k == n_random / 2) wait_drained();
                send_random_sample();
            end
        end

        // Let the last drive beats out, then give the block time to settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d samples across %0d register settings, from reset values to",
                 n_sent, N_PHASES);
        $display("all-ones, crossed limits and frozen integral; %0d drive beats checked, %0d at a limit.",
                 sb.n_checked, sb.n_limited);
        if (sb.errors == 0 && sb.pending_drive.size() == 0) begin
            $display("pid_levitation_controller_top_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d drive beats never seen",
                     sb.errors, sb.pending_drive.size());
            $display("pid_levitation_controller_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- pid_levitation_controller_top.f -----
+incdir+src
src/pidlev_pkg.sv
src/pidlev_if.sv
src/pidlev_ser_mul.sv
src/pidlev_ser_div.sv
src/pid_levitation_controller_top.sv
tb/sv/pid_levitation_controller_top_tb.sv
